>>> hw/rtl/egm_pkg.sv
package egm_pkg;

    // image geometry limits
    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int PIXEL_BITS   = 8;

    // configuration port
    localparam int CFG_BITS       = 12;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MODE_BITS      = 2;

    // result field
    localparam int MAG_BITS = 11;
    localparam int MAG_MAX  = 2 ** MAG_BITS - 1;

    // derived widths
    localparam int ADDR_BITS     = $clog2(MAX_WIDTH);
    localparam int COL_BITS      = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS      = $clog2(HEIGHT_LIMIT + 1);
    localparam int CNT_BITS_GEO  = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
    localparam int CNT_BITS      = (CNT_BITS_GEO > CFG_BITS) ? CNT_BITS_GEO : CFG_BITS;
    localparam int GRAD_BITS     = PIXEL_BITS + 3;
    localparam int SQ_BITS       = 2 * GRAD_BITS - 2;
    localparam int SUM_BITS      = 2 * GRAD_BITS;
    localparam int ROOT_BITS     = GRAD_BITS;
    localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS + 1);
    localparam int SAT_BITS      = (ROOT_BITS > MAG_BITS) ? ROOT_BITS : MAG_BITS;

    // register reset values
    localparam logic [CFG_BITS-1:0] LINE_WIDTH_RESET   = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = CFG_BITS'(480);

    // kernel pair codes, any other code runs sobel
    localparam logic [MODE_BITS-1:0] MODE_SOBEL   = MODE_BITS'(0);
    localparam logic [MODE_BITS-1:0] MODE_PREWITT = MODE_BITS'(1);
    localparam logic [MODE_BITS-1:0] MODE_ROBERTS = MODE_BITS'(2);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OPERATOR_MODE = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_WIDTH    = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT  = CFG_INDEX_BITS'(2);

    typedef logic [PIXEL_BITS-1:0]       pixel_t;
    typedef logic signed [GRAD_BITS-1:0] grad_t;

    typedef struct packed {
        pixel_t pixel;
        logic   is_pad;
    } pix_beat_t;

    typedef struct packed {
        logic [MAG_BITS-1:0] magnitude;
        logic                end_of_line;
        logic                end_of_frame;
    } res_beat_t;

    // one line store word: row two above, row above
    typedef struct packed {
        pixel_t row_b;
        pixel_t row_a;
    } line_word_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
    } line_rd_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        line_word_t           word;
    } line_wr_t;

    // new window column, top to bottom
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        logic shift;
        logic clear_left;
        logic grad;
    } win_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_GRAD,
        S_SQR,
        S_START,
        S_ROOT,
        S_OUT
    } egm_state_t;

endpackage

>>> hw/rtl/egm_line_buffer.sv
module egm_line_buffer (
    input  logic               clk,
    input  egm_pkg::line_rd_t  rd,
    output egm_pkg::line_word_t rd_word,
    input  egm_pkg::line_wr_t  wr
);
    import egm_pkg::*;

    // both line stores side by side in one word
    line_word_t line_mem [MAX_WIDTH];
    line_word_t rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            line_mem[wr.addr] <= wr.word;
        end
        if (rd.en)
        begin
            rd_word_reg <= line_mem[rd.addr];
        end
    end

    assign rd_word = rd_word_reg;

endmodule

>>> hw/rtl/egm_window.sv
module egm_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  egm_pkg::win_ctrl_t            ctrl,
    input  egm_pkg::column_t              column,
    input  logic [egm_pkg::MODE_BITS-1:0] mode,
    output egm_pkg::grad_t                gx,
    output egm_pkg::grad_t                gy
);
    import egm_pkg::*;

    pixel_t win_reg  [3][3];
    pixel_t win_next [3][3];
    grad_t  q        [3][3];
    grad_t  gx_reg;
    grad_t  gy_reg;
    grad_t  gx_next;
    grad_t  gy_next;
    grad_t  w01;
    grad_t  w10;
    grad_t  w12;
    grad_t  w21;

    // [row][col], col 2 is the newest
    always_comb
    begin
        win_next = win_reg;
        if (ctrl.shift)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_next[k][0] = ctrl.clear_left ? '0 : win_reg[k][1];
                win_next[k][1] = ctrl.clear_left ? '0 : win_reg[k][2];
            end
            win_next[0][2] = column.top;
            win_next[1][2] = column.mid;
            win_next[2][2] = column.bot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                q[k][j] = signed'(GRAD_BITS'(win_reg[k][j]));
            end
        end
        // center weights: one for prewitt, two for sobel
        if (mode == MODE_PREWITT)
        begin
            w01 = q[0][1];
            w10 = q[1][0];
            w12 = q[1][2];
            w21 = q[2][1];
        end
        else
        begin
            w01 = q[0][1] <<< 1;
            w10 = q[1][0] <<< 1;
            w12 = q[1][2] <<< 1;
            w21 = q[2][1] <<< 1;
        end
        case (mode)
            MODE_ROBERTS:
            begin
                gx_next = q[0][0] - q[1][1];
                gy_next = q[1][0] - q[0][1];
            end
            default:
            begin
                gx_next = (q[0][2] + w12 + q[2][2]) - (q[0][0] + w10 + q[2][0]);
                gy_next = (q[2][0] + w21 + q[2][2]) - (q[0][0] + w01 + q[0][2]);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.grad)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
    end

    assign gx = gx_reg;
    assign gy = gy_reg;

endmodule

>>> hw/rtl/egm_isqrt.sv
module egm_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [egm_pkg::SUM_BITS-1:0]  operand,
    output logic                          done,
    output logic [egm_pkg::ROOT_BITS-1:0] root
);
    import egm_pkg::*;

    logic [SUM_BITS-1:0]      op_reg;
    logic [ROOT_BITS+1:0]     rem_reg;
    logic [ROOT_BITS-1:0]     root_reg;
    logic [ROOT_CNT_BITS-1:0] cnt_reg;
    logic [ROOT_CNT_BITS-1:0] cnt_next;
    logic                     done_reg;
    logic                     done_next;
    logic [ROOT_BITS+1:0]     rem_shift;
    logic [ROOT_BITS+1:0]     trial;
    logic                     fits;

    // one result bit per cycle, restoring
    assign rem_shift = {rem_reg[ROOT_BITS-1:0], op_reg[SUM_BITS-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = rem_shift >= trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = ROOT_CNT_BITS'(ROOT_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == ROOT_CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            op_reg   <= {op_reg[SUM_BITS-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> hw/rtl/edge_gradient_magnitude_unit.sv
// gradient magnitude on a raster pixel stream, sobel / prewitt / roberts
//
// pixel channel (pix_valid, pix_stall, pix_data): one beat per item in raster
// order; every row carries line_width pixels plus one pad item, every frame
// frame_height rows plus one pad row of line_width+1 items.
// result channel (res_valid, res_stall, res_data): one beat per real pixel in
// raster order; the result for (x,y) is produced by the item at (x+1,y+1).
// config port (cfg_write, cfg_index, cfg_data): write only while idle.
//
// an item that makes no result is a line store read, then window update and
// write back. an item that makes a result goes on through the gradient
// register, the squares and the bit-serial square root unit; its result
// beat is loaded once the root is done and the output register is free.
// pix_stall stays high while an item is in work; a result that waits on a high
// res_stall holds in the output register and the next item is still taken,
// the block blocks only when a second result is ready and the first is unread.
// reset clears counters, window, config and output valid; the line stores are
// not cleared, rows above the top are gated to zero instead.
module edge_gradient_magnitude_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pix_valid,
    output logic                               pix_stall,
    input  egm_pkg::pix_beat_t                 pix_data,
    output logic                               res_valid,
    input  logic                               res_stall,
    output egm_pkg::res_beat_t                 res_data,
    input  logic                               cfg_write,
    input  logic [egm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [egm_pkg::CFG_BITS-1:0]       cfg_data
);
    import egm_pkg::*;

    // config registers
    logic [MODE_BITS-1:0] mode_reg;
    logic [CFG_BITS-1:0]  line_width_reg;
    logic [CFG_BITS-1:0]  frame_height_reg;

    // position in the padded frame
    logic [CNT_BITS-1:0] col_reg;
    logic [CNT_BITS-1:0] row_reg;
    logic [CNT_BITS-1:0] col_next;
    logic [CNT_BITS-1:0] row_next;

    // clamped geometry
    logic [CNT_BITS-1:0] width_ext;
    logic [CNT_BITS-1:0] height_ext;
    logic [CNT_BITS-1:0] width_eff;
    logic [CNT_BITS-1:0] height_eff;

    // item in work
    logic                 pix_accept;
    logic                 pad_col;
    logic                 pad_row;
    pixel_t               pix_gated;
    pixel_t               pix_reg;
    logic                 pad_col_reg;
    logic                 pad_row_reg;
    logic                 row_ge1_reg;
    logic                 row_ge2_reg;
    logic                 col_zero_reg;
    logic                 has_res_reg;
    logic                 eol_reg;
    logic                 eof_reg;
    logic [ADDR_BITS-1:0] addr_reg;

    // control
    egm_state_t state_reg;
    egm_state_t state_next;
    logic       root_start;
    logic       out_load;
    logic       out_free;
    logic       sq_en;
    win_ctrl_t  win_ctrl;

    // datapath
    line_rd_t                  line_rd;
    line_wr_t                  line_wr;
    line_word_t                line_word;
    column_t                   column;
    grad_t                     gx;
    grad_t                     gy;
    logic signed [SUM_BITS-1:0] prod_x;
    logic signed [SUM_BITS-1:0] prod_y;
    logic [SQ_BITS-1:0]        sq_x_reg;
    logic [SQ_BITS-1:0]        sq_y_reg;
    logic [SUM_BITS-1:0]       sum_sq;
    logic                      root_done;
    logic [ROOT_BITS-1:0]      root;
    logic [SAT_BITS-1:0]       root_ext;
    logic [MAG_BITS-1:0]       mag_sat;

    // output register
    logic      res_valid_reg;
    res_beat_t res_data_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_SOBEL;
            line_width_reg   <= LINE_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OPERATOR_MODE: mode_reg         <= cfg_data[MODE_BITS-1:0];
                CFG_LINE_WIDTH:    line_width_reg   <= cfg_data;
                CFG_FRAME_HEIGHT:  frame_height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // zero acts as one, oversize acts as the limit
    assign width_ext  = CNT_BITS'(line_width_reg);
    assign height_ext = CNT_BITS'(frame_height_reg);

    always_comb
    begin
        if (width_ext == '0)
        begin
            width_eff = CNT_BITS'(1);
        end
        else if (width_ext > CNT_BITS'(MAX_WIDTH))
        begin
            width_eff = CNT_BITS'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        if (height_ext == '0)
        begin
            height_eff = CNT_BITS'(1);
        end
        else if (height_ext > CNT_BITS'(HEIGHT_LIMIT))
        begin
            height_eff = CNT_BITS'(HEIGHT_LIMIT);
        end
        else
        begin
            height_eff = height_ext;
        end
    end

    // ------------------------------------------------------- accept, counters
    assign pix_stall  = (state_reg != S_IDLE);
    assign pix_accept = pix_valid && !pix_stall;

    // the counters alone decide pad positions, a counter at or past the limit is pad
    assign pad_col   = col_reg >= width_eff;
    assign pad_row   = row_reg >= height_eff;
    assign pix_gated = (pad_col || pad_row || pix_data.is_pad) ? '0 : pix_data.pixel;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_accept)
        begin
            if (pad_col)
            begin
                col_next = '0;
                row_next = pad_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // item facts, taken at accept
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            pix_reg      <= pix_gated;
            pad_col_reg  <= pad_col;
            pad_row_reg  <= pad_row;
            row_ge1_reg  <= (row_reg >= CNT_BITS'(1));
            row_ge2_reg  <= (row_reg >= CNT_BITS'(2));
            col_zero_reg <= (col_reg == '0);
            has_res_reg  <= (col_reg != '0) && (row_reg != '0)
                            && (col_reg <= width_eff) && (row_reg <= height_eff);
            eol_reg      <= (col_reg == width_eff);
            eof_reg      <= (col_reg == width_eff) && (row_reg == height_eff);
            addr_reg     <= col_reg[ADDR_BITS-1:0];
        end
    end

    // ------------------------------------------------------------ line stores
    // read at accept, modify and write back in the next cycle; the next item
    // cannot read before the write lands
    assign line_rd.en   = pix_accept && !pad_col;
    assign line_rd.addr = col_reg[ADDR_BITS-1:0];

    assign line_wr.en         = (state_reg == S_WIN) && !pad_col_reg && !pad_row_reg;
    assign line_wr.addr       = addr_reg;
    assign line_wr.word.row_b = line_word.row_a;
    assign line_wr.word.row_a = pix_reg;

    egm_line_buffer u_line_buffer (
        .clk     (clk),
        .rd      (line_rd),
        .rd_word (line_word),
        .wr      (line_wr)
    );

    // rows above the image and pad columns enter the window as zero
    assign column.top = (!pad_col_reg && row_ge2_reg) ? line_word.row_b : '0;
    assign column.mid = (!pad_col_reg && row_ge1_reg) ? line_word.row_a : '0;
    assign column.bot = pix_reg;

    // ------------------------------------------------------- window, kernels
    egm_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (win_ctrl),
        .column (column),
        .mode   (mode_reg),
        .gx     (gx),
        .gy     (gy)
    );

    // ------------------------------------------------------ squares and root
    assign prod_x = gx * gx;
    assign prod_y = gy * gy;

    always_ff @(posedge clk)
    begin
        if (sq_en)
        begin
            sq_x_reg <= prod_x[SQ_BITS-1:0];
            sq_y_reg <= prod_y[SQ_BITS-1:0];
        end
    end

    assign sum_sq = SUM_BITS'(sq_x_reg) + SUM_BITS'(sq_y_reg);

    egm_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (root_start),
        .operand (sum_sq),
        .done    (root_done),
        .root    (root)
    );

    // saturate to the result field
    assign root_ext = SAT_BITS'(root);
    assign mag_sat  = (root_ext > SAT_BITS'(MAG_MAX)) ? MAG_BITS'(MAG_MAX)
                                                      : MAG_BITS'(root_ext);

    // --------------------------------------------------------- sequencer
    assign out_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        root_start          = 1'b0;
        out_load            = 1'b0;
        sq_en               = 1'b0;
        win_ctrl.shift      = 1'b0;
        win_ctrl.clear_left = col_zero_reg;
        win_ctrl.grad       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (pix_accept)
                begin
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                win_ctrl.shift = 1'b1;
                state_next     = has_res_reg ? S_GRAD : S_IDLE;
            end
            S_GRAD:
            begin
                win_ctrl.grad = 1'b1;
                state_next    = S_SQR;
            end
            S_SQR:
            begin
                sq_en      = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                root_start = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                // root holds in the unit until the next start
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_data_reg.magnitude    <= mag_sat;
            res_data_reg.end_of_line  <= eol_reg;
            res_data_reg.end_of_frame <= eof_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

>>> hw/rtl/egm_checker.sv
module egm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               pix_valid,
    input logic               pix_stall,
    input logic               res_valid,
    input logic               res_stall,
    input egm_pkg::res_beat_t res_data
);
    logic pix_accept;

    assign pix_accept = pix_valid && !pix_stall;

    // one item at a time: busy right after each accepted beat
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        pix_accept |=> pix_stall
    ) else $error("pixel beat taken on the cycle after an accept");

    // a result is only produced while an item is in work
    a_result_from_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_stall)
    ) else $error("result beat appeared while idle");

    // end of frame is always also end of line
    a_eof_is_eol: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res_data.end_of_frame || res_data.end_of_line)
    ) else $error("end of frame without end of line");

    a_res_valid_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid
    ) else $error("result valid dropped under stall");

    a_res_data_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_data)
    ) else $error("result beat changed under stall");

endmodule

bind edge_gradient_magnitude_unit egm_checker u_egm_checker (.*);

>>> verif/edge_gradient_magnitude_unit_test.sv
`timescale 1ns / 100ps

module edge_gradient_magnitude_unit_test;

    import egm_pkg::*;

    // cycles from an accepted pixel beat to its result beat
    localparam int ITEM_LATENCY    = ROOT_BITS + 5;
    localparam int SETTLE_CYCLES   = ITEM_LATENCY + 8;
    localparam int RANDOM_ITEMS    = 1150;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PRESSURE_FRAME  = 4;
    // a mode code outside the list, runs as sobel
    localparam logic [MODE_BITS-1:0] MODE_UNKNOWN = MODE_BITS'(3);

    typedef enum logic {
        STEP_REGISTER,
        STEP_PIXEL
    } step_kind_t;

    // one row of the directed stimulus: a register write or a pixel beat,
    // optionally with the result beat it causes typed in by hand
    typedef struct {
        step_kind_t                kind;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_BITS-1:0]       value;
        pix_beat_t                 beat;
        bit                        typed;
        res_beat_t                 typed_res;
    } directed_step_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                      pix_valid = 1'b0;
    logic                      pix_stall;
    pix_beat_t                 pix_data  = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    res_beat_t                 res_data;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_data  = '0;

    // idling knobs, percent of cycles
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;

    // long receiver hold-off, run by its own process
    logic hold_results   = 1'b0;
    bit   pressure_armed = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned pixels_sent    = 0;

    // expected result beats, oldest first
    res_beat_t pending_magnitudes [$];
    res_beat_t oldest_magnitude;

    // predictor copy of the registers
    logic [MODE_BITS-1:0] mode_reg   = MODE_SOBEL;
    logic [CFG_BITS-1:0]  width_reg  = LINE_WIDTH_RESET;
    logic [CFG_BITS-1:0]  height_reg = FRAME_HEIGHT_RESET;

    // predictor copy of the line stores, window and raster position
    pixel_t      store_one_up [MAX_WIDTH];
    pixel_t      store_two_up [MAX_WIDTH];
    int          window_px    [9];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    directed_step_t directed_steps [$];

    edge_gradient_magnitude_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    // geometry the block really runs with, out of range values pinned
    function automatic int unsigned clamped_width();
        int unsigned w;
        w = width_reg;
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned clamped_height();
        int unsigned h;
        h = height_reg;
        if (h == 0)
            h = 1;
        if (h > HEIGHT_LIMIT)
            h = HEIGHT_LIMIT;
        return h;
    endfunction

    function automatic int unsigned floor_sqrt(input int unsigned value);
        int unsigned root;
        int unsigned trial;
        int b;
        root = 0;
        for (b = 15; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= value)
                root = trial;
        end
        return root;
    endfunction

    // advance the window by one pixel beat; returns 1 when the beat
    // completes the neighborhood of a real pixel
    function automatic bit predict_gradient(input pix_beat_t beat, output res_beat_t res);
        int unsigned w, h, c, r, mag;
        bit pad_col, pad_row, has_result;
        int v, top, mid, bot, gx, gy, m, k;
        w = clamped_width();
        h = clamped_height();
        c = col_pos;
        r = row_pos;
        // the counters alone decide what is pad, the flag can only zero a pixel
        pad_col = (c >= w);
        pad_row = (r >= h);
        v = (pad_col || pad_row || beat.is_pad) ? 0 : int'(beat.pixel);
        top = 0;
        mid = 0;
        bot = 0;
        if (!pad_col && c < MAX_WIDTH)
        begin
            // rows above the top are gated, the store is not looked at
            if (r >= 2)
                top = store_two_up[c];
            if (r >= 1)
                mid = store_one_up[c];
            bot = v;
            if (!pad_row)
            begin
                store_two_up[c] = store_one_up[c];
                store_one_up[c] = pixel_t'(v);
            end
        end
        for (k = 0; k < 3; k++)
        begin
            window_px[k * 3]     = window_px[k * 3 + 1];
            window_px[k * 3 + 1] = window_px[k * 3 + 2];
        end
        window_px[2] = top;
        window_px[5] = mid;
        window_px[8] = bot;
        // left border: columns left of the image are zero
        if (c == 0)
        begin
            for (k = 0; k < 3; k++)
            begin
                window_px[k * 3]     = 0;
                window_px[k * 3 + 1] = 0;
            end
        end
        has_result = (c >= 1 && r >= 1 && c <= w && r <= h);
        res = '0;
        if (has_result)
        begin
            if (mode_reg == MODE_ROBERTS)
            begin
                gx = window_px[0] - window_px[4];
                gy = window_px[3] - window_px[1];
            end
            else
            begin
                // prewitt weighs the middle taps 1, sobel and unknown codes 2
                m  = (mode_reg == MODE_PREWITT) ? 1 : 2;
                gx = (window_px[2] + m * window_px[5] + window_px[8])
                   - (window_px[0] + m * window_px[3] + window_px[6]);
                gy = (window_px[6] + m * window_px[7] + window_px[8])
                   - (window_px[0] + m * window_px[1] + window_px[2]);
            end
            mag = floor_sqrt(gx * gx + gy * gy);
            if (mag > MAG_MAX)
                mag = MAG_MAX;
            res.magnitude    = MAG_BITS'(mag);
            res.end_of_line  = (c == w);
            res.end_of_frame = (c == w && r == h);
        end
        // at or past the width limit the counters wrap
        if (c >= w)
        begin
            col_pos = 0;
            row_pos = (r >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
        return has_result;
    endfunction

    // wait until every expected beat is in, then let any item still in work finish
    task automatic settle_block();
        pix_valid <= 1'b0;
        while (pending_magnitudes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_BITS-1:0] value);
        settle_block();
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (index)
            CFG_OPERATOR_MODE: mode_reg   = value[MODE_BITS-1:0];
            CFG_LINE_WIDTH:    width_reg  = value;
            CFG_FRAME_HEIGHT:  height_reg = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // offer one pixel beat and hold it until taken; the expectation is the
    // typed one where given, otherwise the predictor's
    task automatic send_pixel(input pix_beat_t beat, input bit typed, input res_beat_t typed_res);
        res_beat_t predicted;
        bit has_result;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= beat;
        do
            @(posedge clk);
        while (pix_stall);
        pixels_sent++;
        has_result = predict_gradient(beat, predicted);
        if (typed)
            pending_magnitudes.push_back(typed_res);
        else if (has_result)
            pending_magnitudes.push_back(predicted);
    endtask

    function automatic pixel_t random_pixel();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return pixel_t'($urandom_range(255));
        endcase
    endfunction

    function automatic directed_step_t reg_step(input logic [CFG_INDEX_BITS-1:0] index,
                                                input logic [CFG_BITS-1:0] value);
        directed_step_t s;
        s = '{STEP_REGISTER, index, value, '0, 1'b0, '0};
        return s;
    endfunction

    function automatic directed_step_t pixel_step(input pixel_t pixel, input logic is_pad);
        directed_step_t s;
        s = '{STEP_PIXEL, '0, '0, '{pixel, is_pad}, 1'b0, '0};
        return s;
    endfunction

    function automatic directed_step_t checked_step(input pixel_t pixel, input logic is_pad,
                                                    input int unsigned mag, input logic eol,
                                                    input logic eof);
        directed_step_t s;
        s = '{STEP_PIXEL, '0, '0, '{pixel, is_pad}, 1'b1, '{MAG_BITS'(mag), eol, eof}};
        return s;
    endfunction

    // one padded frame from the current raster position until the counters
    // wrap; a cut frame shrinks the geometry part way through
    task automatic send_frame(input bit cut);
        int unsigned cut_at, sent, w, h;
        bit real_pos, noise;
        pix_beat_t beat;
        w = clamped_width();
        h = clamped_height();
        cut_at = cut ? $urandom_range(1, (w + 1) * (h + 1) - 1) : 0;
        sent = 0;
        do
        begin
            if (cut && sent == cut_at)
            begin
                // only shrink: wider rows would read store columns never written
                if (clamped_width() > 1 && $urandom_range(1))
                    write_register(CFG_LINE_WIDTH, CFG_BITS'($urandom_range(1, clamped_width())));
                else
                    write_register(CFG_FRAME_HEIGHT,
                                   CFG_BITS'($urandom_range(1, clamped_height())));
            end
            real_pos = (col_pos < clamped_width() && row_pos < clamped_height());
            noise = ($urandom_range(99) < 8);
            beat.pixel  = (real_pos || $urandom_range(1)) ? random_pixel() : pixel_t'(0);
            beat.is_pad = real_pos ? noise : !noise;
            send_pixel(beat, 1'b0, '0);
            sent++;
        end
        while (col_pos != 0 || row_pos != 0);
    endtask

    // long receiver hold-off while the sender keeps offering beats
    initial
    begin
        wait (pressure_armed);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    // result side: check the beat taken at this edge, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_magnitudes.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                oldest_magnitude = pending_magnitudes.pop_front();
                if (res_data.magnitude !== oldest_magnitude.magnitude)
                    report_mismatch($sformatf("magnitude %0d, want %0d",
                                              res_data.magnitude, oldest_magnitude.magnitude));
                if (res_data.end_of_line !== oldest_magnitude.end_of_line)
                    report_mismatch($sformatf("end_of_line %b, want %b",
                                              res_data.end_of_line, oldest_magnitude.end_of_line));
                if (res_data.end_of_frame !== oldest_magnitude.end_of_frame)
                    report_mismatch($sformatf("end_of_frame %b, want %b",
                                              res_data.end_of_frame,
                                              oldest_magnitude.end_of_frame));
            end
            results_seen++;
        end
        res_stall <= hold_results || ($urandom_range(99) < receiver_stall_pct);
    end

    initial
    begin
        directed_step_t step;
        int i;
        int unsigned frame_idx, random_start, pick;
        for (i = 0; i < MAX_WIDTH; i++)
        begin
            store_one_up[i] = '0;
            store_two_up[i] = '0;
        end
        for (i = 0; i < 9; i++)
            window_px[i] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mode left at its reset value (sobel); 2x1 image, dark then bright
        directed_steps.push_back(reg_step(CFG_LINE_WIDTH, CFG_BITS'(2)));
        directed_steps.push_back(reg_step(CFG_FRAME_HEIGHT, CFG_BITS'(1)));
        directed_steps.push_back(pixel_step(8'h00, 1'b0));
        directed_steps.push_back(pixel_step(8'hff, 1'b0));
        directed_steps.push_back(pixel_step(8'h5a, 1'b1));
        directed_steps.push_back(pixel_step(8'h00, 1'b1));
        directed_steps.push_back(checked_step(8'h00, 1'b1, 510, 1'b0, 1'b0));
        directed_steps.push_back(checked_step(8'h00, 1'b1, 0, 1'b1, 1'b1));
        // roberts, zero width and height act as one; pad position with flag clear
        directed_steps.push_back(reg_step(CFG_OPERATOR_MODE, CFG_BITS'(MODE_ROBERTS)));
        directed_steps.push_back(reg_step(CFG_LINE_WIDTH, CFG_BITS'(0)));
        directed_steps.push_back(reg_step(CFG_FRAME_HEIGHT, CFG_BITS'(0)));
        directed_steps.push_back(pixel_step(8'd200, 1'b0));
        directed_steps.push_back(pixel_step(8'hff, 1'b0));
        directed_steps.push_back(pixel_step(8'ha5, 1'b1));
        directed_steps.push_back(checked_step(8'hff, 1'b1, 200, 1'b1, 1'b1));
        // prewitt, a real position flagged as pad reads as zero
        directed_steps.push_back(reg_step(CFG_OPERATOR_MODE, CFG_BITS'(MODE_PREWITT)));
        directed_steps.push_back(reg_step(CFG_LINE_WIDTH, CFG_BITS'(2)));
        directed_steps.push_back(reg_step(CFG_FRAME_HEIGHT, CFG_BITS'(1)));
        directed_steps.push_back(pixel_step(8'd100, 1'b0));
        directed_steps.push_back(pixel_step(8'd50, 1'b1));
        directed_steps.push_back(pixel_step(8'h00, 1'b1));
        for (i = 0; i < 3; i++)
            directed_steps.push_back(pixel_step(8'h00, 1'b1));
        // unknown mode, widest geometry, then shrink mid frame: width to
        // below the column count, height to exactly the row count
        directed_steps.push_back(reg_step(CFG_OPERATOR_MODE, CFG_BITS'(MODE_UNKNOWN)));
        directed_steps.push_back(reg_step(CFG_LINE_WIDTH, '1));
        directed_steps.push_back(reg_step(CFG_FRAME_HEIGHT, '1));
        directed_steps.push_back(pixel_step(8'hff, 1'b0));
        directed_steps.push_back(pixel_step(8'h00, 1'b0));
        directed_steps.push_back(pixel_step(8'd128, 1'b0));
        directed_steps.push_back(reg_step(CFG_LINE_WIDTH, CFG_BITS'(2)));
        directed_steps.push_back(pixel_step(8'd9, 1'b0));
        directed_steps.push_back(pixel_step(8'd17, 1'b0));
        directed_steps.push_back(pixel_step(8'hff, 1'b0));
        directed_steps.push_back(pixel_step(8'h00, 1'b1));
        directed_steps.push_back(reg_step(CFG_FRAME_HEIGHT, CFG_BITS'(2)));
        for (i = 0; i < 3; i++)
            directed_steps.push_back(pixel_step(8'h00, 1'b1));

        foreach (directed_steps[i])
        begin
            step = directed_steps[i];
            if (step.kind == STEP_REGISTER)
                write_register(step.index, step.value);
            else
                send_pixel(step.beat, step.typed, step.typed_res);
        end

        // random frames, idling pattern rotating frame by frame
        random_start = pixels_sent;
        frame_idx = 0;
        while (pixels_sent - random_start < RANDOM_ITEMS)
        begin
            case (frame_idx % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 86;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 86;
                end
                default:
                begin
                    sender_idle_pct    = 24;
                    receiver_stall_pct = 24;
                end
            endcase
            if (frame_idx == PRESSURE_FRAME)
            begin
                // big enough frame that the block fills up behind the hold-off
                write_register(CFG_LINE_WIDTH, CFG_BITS'(8));
                write_register(CFG_FRAME_HEIGHT, CFG_BITS'(6));
                pressure_armed = 1'b1;
            end
            else if (frame_idx == 0 || $urandom_range(1))
            begin
                write_register(CFG_OPERATOR_MODE, CFG_BITS'($urandom_range(3)));
                pick = $urandom_range(19);
                if (pick == 0)
                    write_register(CFG_LINE_WIDTH, CFG_BITS'(0));
                else if (pick < 3)
                    write_register(CFG_LINE_WIDTH, CFG_BITS'($urandom_range(9, 40)));
                else
                    write_register(CFG_LINE_WIDTH, CFG_BITS'($urandom_range(1, 8)));
                if ($urandom_range(19) == 0)
                    write_register(CFG_FRAME_HEIGHT, CFG_BITS'(0));
                else
                    write_register(CFG_FRAME_HEIGHT, CFG_BITS'($urandom_range(1, 5)));
            end
            send_frame(frame_idx != PRESSURE_FRAME && $urandom_range(9) == 0);
            frame_idx++;
        end

        // drain: every expected beat in, then quiet before the final check
        settle_block();
        repeat (2 * ITEM_LATENCY) @(posedge clk);
        if (pending_magnitudes.size() != 0)
            report_mismatch($sformatf("%0d expected beats never came",
                                      pending_magnitudes.size()));
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
